FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/cldl_pkg.sv
// Package with types, op codes and constants for the circular list block.
package cldl_pkg;
  localparam int DataWidth = 32;
  localparam int Capacity = 256;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FWD    = 3'd2,
    OP_BACK   = 3'd3,
    OP_HEAD   = 3'd4,
    OP_POP    = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] data_in;
    logic [9:0]  move_steps;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  count;
    logic        cursor_valid;
    logic [31:0] cursor_value;
  } out_t;
endpackage

FILE: rtl/cldl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module cldl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/cldl_front.sv
// Front end: a two-entry queue toward the list engine.
module cldl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cldl_pkg::in_t in_item,
  output logic          q_valid,
  input  logic          q_take,
  output cldl_pkg::in_t q_item
);
  cldl_pkg::in_t slot0;
  cldl_pkg::in_t slot1;
  logic [1:0] fill;
  logic push;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_item = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, q_take};
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      slot0 <= slot1;
      if (push && fill == 2'd1) slot0 <= in_item;
      if (push && fill == 2'd2) slot1 <= in_item;
    end else begin
      if (push && fill == 2'd0) slot0 <= in_item;
      if (push && fill == 2'd1) slot1 <= in_item;
    end
  end
endmodule

FILE: rtl/cldl_back.sv
// Back end: sequencer that updates the linked list memories and builds results.
module cldl_back #(
  parameter int DataWidth = cldl_pkg::DataWidth,
  parameter int Capacity = cldl_pkg::Capacity
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_take,
  input  cldl_pkg::in_t  q_item,
  output logic           out_valid,
  input  logic           out_stall,
  output cldl_pkg::out_t out_item
);
  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLR    = 10'b0000000010,
    S_FREE   = 10'b0000000100,
    S_RDC    = 10'b0000001000,
    S_LINK1  = 10'b0000010000,
    S_LINK2  = 10'b0000100000,
    S_STEP   = 10'b0001000000,
    S_RDVAL  = 10'b0010000000,
    S_WAITV  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  cldl_pkg::in_t cur;
  logic [AW-1:0] head, tail, cursor, sel, nx, tgt;
  logic [CW-1:0] count, free_top;
  logic [AW:0] clr_idx;
  logic [9:0] steps;
  logic [1:0] status;
  logic out_full;

  logic nl_we, pl_we, dt_we, fs_we;
  logic [AW-1:0] nl_wa, pl_wa, dt_wa, fs_wa, nl_wd, pl_wd, fs_wd;
  logic [AW-1:0] nl_ra, pl_ra, dt_ra, fs_ra, nl_rd, pl_rd, fs_rd;
  logic [DataWidth-1:0] dt_wd, dt_rd;

  cldl_ram #(.Width(AW), .Depth(Capacity)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd));
  cldl_ram #(.Width(AW), .Depth(Capacity)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
  cldl_ram #(.Width(DataWidth), .Depth(Capacity)) u_data (
    .clk(clk), .we(dt_we), .waddr(dt_wa), .wdata(dt_wd), .raddr(dt_ra), .rdata(dt_rd));
  cldl_ram #(.Width(AW), .Depth(Capacity)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

  assign q_take = (state == S_IDLE) && q_valid && !out_full;
  assign out_valid = out_full;
  assign nl_ra = (state == S_STEP) ? nx : sel;
  assign pl_ra = (state == S_STEP) ? nx : sel;
  assign dt_ra = cursor;
  assign fs_ra = AW'(free_top - CW'(1));

  always_comb begin
    nl_we = 1'b0; nl_wa = '0; nl_wd = '0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0;
    dt_we = 1'b0; dt_wa = '0; dt_wd = cur.data_in[DataWidth-1:0];
    fs_we = 1'b0; fs_wa = '0; fs_wd = '0;
    if (state == S_CLR) begin
      fs_we = 1'b1; fs_wa = clr_idx[AW-1:0]; fs_wd = clr_idx[AW-1:0];
    end else if (state == S_LINK1) begin
      unique case (cur.op)
        cldl_pkg::OP_APPEND: begin
          dt_we = 1'b1; dt_wa = fs_rd;
          nl_we = 1'b1; nl_wa = fs_rd; nl_wd = (count == '0) ? fs_rd : head;
          pl_we = 1'b1; pl_wa = fs_rd; pl_wd = (count == '0) ? fs_rd : tail;
        end
        cldl_pkg::OP_REMOVE: begin
          nl_we = 1'b1; nl_wa = pl_rd; nl_wd = nl_rd;
          pl_we = 1'b1; pl_wa = nl_rd; pl_wd = pl_rd;
        end
        cldl_pkg::OP_POP: begin
          nl_we = 1'b1; nl_wa = pl_rd; nl_wd = head;
          pl_we = 1'b1; pl_wa = head; pl_wd = pl_rd;
        end
        default: ;
      endcase
    end else if (state == S_LINK2) begin
      unique case (cur.op)
        cldl_pkg::OP_APPEND: begin
          if (count != CW'(1)) begin
            nl_we = 1'b1; nl_wa = tail; nl_wd = tgt;
            pl_we = 1'b1; pl_wa = head; pl_wd = tgt;
          end
        end
        cldl_pkg::OP_REMOVE, cldl_pkg::OP_POP: begin
          fs_we = 1'b1; fs_wa = AW'(free_top); fs_wd = tgt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_take) state_next = S_RDC;
      S_CLR:   if (clr_idx == (AW+1)'(Capacity - 1)) state_next = S_IDLE;
      S_FREE:  state_next = S_LINK1;
      S_RDC:   state_next = S_LINK1;
      S_LINK1: state_next = S_LINK2;
      S_LINK2: state_next = S_STEP;
      S_STEP:  state_next = S_RDVAL;
      S_RDVAL: state_next = S_WAITV;
      S_WAITV: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      free_top <= CW'(Capacity);
      count <= '0;
      head <= '0; tail <= '0; cursor <= '0;
      out_full <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_take) begin
            cur <= q_item;
            steps <= q_item.move_steps;
            sel <= cursor;
            status <= cldl_pkg::ST_DONE;
            state <= S_RDC;
            if (q_item.op == cldl_pkg::OP_APPEND) begin
              if (count == CW'(Capacity) || free_top == '0) begin
                status <= cldl_pkg::ST_FULL;
                state <= S_RDVAL;
              end
            end else if (q_item.op == cldl_pkg::OP_NONE) begin
              state <= S_RDVAL;
            end else if (count == '0) begin
              status <= cldl_pkg::ST_EMPTY;
              state <= S_RDVAL;
            end else if (q_item.op == cldl_pkg::OP_POP) begin
              sel <= tail;
            end
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          state <= state_next;
        end
        S_RDC: begin
          state <= S_LINK1;
          unique case (cur.op)
            cldl_pkg::OP_HEAD: begin cursor <= head; state <= S_RDVAL; end
            cldl_pkg::OP_CLEAR: begin
              free_top <= CW'(Capacity); count <= '0;
              head <= '0; tail <= '0; cursor <= '0;
              clr_idx <= '0; state <= S_CLR;
              out_full <= 1'b1;
            end
            cldl_pkg::OP_FWD, cldl_pkg::OP_BACK: begin
              nx <= cursor; state <= S_STEP;
            end
            cldl_pkg::OP_REMOVE, cldl_pkg::OP_POP: begin
              if (count == CW'(1)) begin
                free_top <= CW'(Capacity); count <= '0;
                head <= '0; tail <= '0; cursor <= '0;
                clr_idx <= '0; state <= S_CLR;
                out_full <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_LINK1: begin
          state <= S_LINK2;
          unique case (cur.op)
            cldl_pkg::OP_APPEND: begin
              tgt <= fs_rd;
              free_top <= free_top - CW'(1);
              if (count == '0) begin
                head <= fs_rd; cursor <= fs_rd;
              end
              count <= count + CW'(1);
            end
            cldl_pkg::OP_REMOVE: begin
              tgt <= sel;
              if (sel == head) head <= nl_rd;
              if (sel == tail) tail <= pl_rd;
              cursor <= nl_rd;
              count <= count - CW'(1);
            end
            cldl_pkg::OP_POP: begin
              tgt <= sel;
              if (cursor == sel) cursor <= pl_rd;
              tail <= pl_rd;
              count <= count - CW'(1);
            end
            default: ;
          endcase
        end
        S_LINK2: begin
          if (cur.op == cldl_pkg::OP_FWD || cur.op == cldl_pkg::OP_BACK) begin
            nx <= (cur.op == cldl_pkg::OP_FWD) ? nl_rd : pl_rd;
            steps <= steps - 10'd1;
            state <= S_STEP;
          end else begin
            if (cur.op == cldl_pkg::OP_APPEND) tail <= tgt;
            if ((cur.op == cldl_pkg::OP_REMOVE || cur.op == cldl_pkg::OP_POP)
                && free_top < CW'(Capacity)) begin
              free_top <= free_top + CW'(1);
            end
            state <= S_RDVAL;
          end
        end
        S_STEP: begin
          if (steps == '0) begin
            cursor <= nx;
            state <= S_RDVAL;
          end else begin
            state <= S_LINK2;
          end
        end
        S_RDVAL: state <= S_WAITV;
        S_WAITV: state <= S_OUT;
        S_OUT: begin
          out_item.status <= status;
          out_item.count <= 9'(count);
          out_item.cursor_valid <= (count != '0);
          out_item.cursor_value <= (count != '0) ? 32'(dt_rd) : 32'd0;
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_RDC && (cur.op == cldl_pkg::OP_CLEAR ||
          ((cur.op == cldl_pkg::OP_REMOVE || cur.op == cldl_pkg::OP_POP) &&
           count == CW'(1)))) begin
        out_item.status <= cldl_pkg::ST_DONE;
        out_item.count <= '0;
        out_item.cursor_valid <= 1'b0;
        out_item.cursor_value <= '0;
      end
    end
  end
endmodule

FILE: rtl/circular_list_with_cursor_core.sv
// Top level of the circular doubly linked list with cursor.
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_stall   | cldl_pkg::in_t
// out     | output    | out_valid, out_stall | cldl_pkg::out_t
// Each cursor step passes S_LINK2 and S_STEP, due to the registered read of
// the link memories. After reset, and after a clear or the removal of the
// last entry, the free-slot stack is refilled while the engine takes no
// operation from the queue. A held result stalls the engine, not the queue.
module circular_list_with_cursor_core #(
  parameter int DataWidth = cldl_pkg::DataWidth,
  parameter int Capacity = cldl_pkg::Capacity
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cldl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cldl_pkg::out_t out_data
);
  logic q_valid, q_take;
  cldl_pkg::in_t q_item;

  cldl_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_data),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item));

  cldl_back #(.DataWidth(DataWidth), .Capacity(Capacity)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_data));
endmodule

FILE: rtl/cldl_checker.sv
// Port-level checker for the circular list core, with its bind.
`include "assert_macros.svh"
module cldl_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input cldl_pkg::out_t out_data
);
  `CHK_IMPLY(a_cnt_range, clk, rst, out_valid, out_data.count <= 9'd256, "count out of range")
  `CHK_IMPLY(a_cur_valid, clk, rst, out_valid, out_data.cursor_valid == (out_data.count != '0), "bad valid")
  `CHK_IMPLY(a_zero_val, clk, rst, out_valid && !out_data.cursor_valid, out_data.cursor_value == '0, "nonzero")
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
endmodule

bind circular_list_with_cursor_core cldl_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

FILE: bench/tb_circular_list_with_cursor_core.sv
// Testbench for the circular doubly linked list with cursor, checked against a local predictor.
`timescale 1ns / 1ps
module tb_circular_list_with_cursor_core;
  localparam int CAP = cldl_pkg::Capacity;
  localparam int WATCH_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  cldl_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  cldl_pkg::out_t out_data;

  circular_list_with_cursor_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor copy of the list.
  logic [31:0] lst_data [CAP];
  logic [7:0] lst_next [CAP];
  logic [7:0] lst_prev [CAP];
  logic [7:0] lst_free [CAP];
  int unsigned lst_free_top;
  logic [7:0] lst_head, lst_tail, lst_cur;
  int unsigned lst_count;

  cldl_pkg::out_t pending_results[$];
  int errors = 0;
  bit sending_done = 0;
  bit hold_long = 0;
  int idle_cycles = 0;

  typedef struct {
    cldl_pkg::in_t item;
    bit has_fixed;
    cldl_pkg::out_t fixed;
  } row_t;

  function automatic void list_empty_all();
    for (int i = 0; i < CAP; i++) lst_free[i] = i[7:0];
    lst_free_top = CAP;
    lst_head = '0;
    lst_tail = '0;
    lst_cur = '0;
    lst_count = 0;
  endfunction

  function automatic cldl_pkg::out_t list_apply(cldl_pkg::in_t it);
    cldl_pkg::out_t r;
    logic [7:0] s, nx, pv, t, nt;
    r.status = cldl_pkg::ST_DONE;
    if (cldl_pkg::op_t'(it.op) == cldl_pkg::OP_APPEND) begin
      if (lst_count >= CAP || lst_free_top == 0) begin
        r.status = cldl_pkg::ST_FULL;
      end else begin
        lst_free_top--;
        s = lst_free[lst_free_top];
        lst_data[s] = it.data_in;
        if (lst_count == 0) begin
          lst_next[s] = s;
          lst_prev[s] = s;
          lst_head = s;
          lst_tail = s;
          lst_cur = s;
        end else begin
          lst_next[s] = lst_head;
          lst_prev[s] = lst_tail;
          lst_next[lst_tail] = s;
          lst_prev[lst_head] = s;
          lst_tail = s;
        end
        lst_count++;
      end
    end else if (cldl_pkg::op_t'(it.op) != cldl_pkg::OP_NONE) begin
      if (lst_count == 0) begin
        r.status = cldl_pkg::ST_EMPTY;
      end else begin
        case (cldl_pkg::op_t'(it.op))
          cldl_pkg::OP_REMOVE: begin
            if (lst_count <= 1) begin
              list_empty_all();
            end else begin
              s = lst_cur;
              nx = lst_next[s];
              pv = lst_prev[s];
              lst_next[pv] = nx;
              lst_prev[nx] = pv;
              if (s == lst_head) lst_head = nx;
              if (s == lst_tail) lst_tail = pv;
              if (lst_free_top < CAP) begin
                lst_free[lst_free_top] = s;
                lst_free_top++;
              end
              lst_count--;
              lst_cur = nx;
            end
          end
          cldl_pkg::OP_FWD:
            for (int i = 0; i < it.move_steps; i++) lst_cur = lst_next[lst_cur];
          cldl_pkg::OP_BACK:
            for (int i = 0; i < it.move_steps; i++) lst_cur = lst_prev[lst_cur];
          cldl_pkg::OP_HEAD: lst_cur = lst_head;
          cldl_pkg::OP_POP: begin
            if (lst_count == 1) begin
              list_empty_all();
            end else begin
              t = lst_tail;
              nt = lst_prev[t];
              if (lst_cur == t) lst_cur = nt;
              lst_next[nt] = lst_head;
              lst_prev[lst_head] = nt;
              if (lst_free_top < CAP) begin
                lst_free[lst_free_top] = t;
                lst_free_top++;
              end
              lst_tail = nt;
              lst_count--;
            end
          end
          default: list_empty_all();
        endcase
      end
    end
    r.count = lst_count[8:0];
    r.cursor_valid = lst_count > 0;
    r.cursor_value = (lst_count > 0) ? lst_data[lst_cur] : '0;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cldl_pkg::in_t make_item(cldl_pkg::op_t o, logic [31:0] d, logic [9:0] n);
    cldl_pkg::in_t it;
    it.op = o;
    it.data_in = d;
    it.move_steps = n;
    return it;
  endfunction

  function automatic cldl_pkg::out_t make_result(logic [1:0] st, int c, bit v, logic [31:0] val);
    cldl_pkg::out_t r;
    r.status = st;
    r.count = c[8:0];
    r.cursor_valid = v;
    r.cursor_value = val;
    return r;
  endfunction

  task automatic send_item(cldl_pkg::in_t it, bit has_fixed, cldl_pkg::out_t fixed);
    cldl_pkg::out_t p;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    p = list_apply(it);
    if (has_fixed && p !== fixed) begin
      $error("directed row disagrees with predictor: exp %h got %h", fixed, p);
      errors++;
    end
    pending_results.push_back(p);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic cldl_pkg::in_t random_item();
    int p;
    cldl_pkg::op_t o;
    p = $urandom_range(0, 99);
    if (lst_count < 20) begin
      o = (p < 60) ? cldl_pkg::OP_APPEND : cldl_pkg::op_t'($urandom_range(0, 7));
    end else if (p < 35) begin
      o = cldl_pkg::OP_APPEND;
    end else begin
      o = cldl_pkg::op_t'($urandom_range(0, 7));
    end
    if (o == cldl_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) o = cldl_pkg::OP_FWD;
    return make_item(o, $urandom(), ($urandom_range(0, 19) == 0) ?
                     10'($urandom()) : 10'($urandom_range(0, 12)));
  endfunction

  row_t rows[$];
  cldl_pkg::out_t none;

  initial begin
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    list_empty_all();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    rows.push_back('{make_item(cldl_pkg::OP_REMOVE, '0, '0), 1,
                     make_result(cldl_pkg::ST_EMPTY, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_FWD, '0, 10'h3ff), 1,
                     make_result(cldl_pkg::ST_EMPTY, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_POP, '0, '0), 1,
                     make_result(cldl_pkg::ST_EMPTY, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_CLEAR, '0, '0), 1,
                     make_result(cldl_pkg::ST_EMPTY, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_NONE, '1, '1), 1,
                     make_result(cldl_pkg::ST_DONE, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_APPEND, 32'hffffffff, '0), 1,
                     make_result(cldl_pkg::ST_DONE, 1, 1, 32'hffffffff)});
    rows.push_back('{make_item(cldl_pkg::OP_APPEND, 32'h0, '1), 1,
                     make_result(cldl_pkg::ST_DONE, 2, 1, 32'hffffffff)});
    rows.push_back('{make_item(cldl_pkg::OP_APPEND, 32'h5a5a5a5a, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_FWD, '0, 10'd0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_FWD, '0, 10'h3ff), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_BACK, '0, 10'd1), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_BACK, '1, 10'h3ff), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_HEAD, '0, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_POP, '0, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_BACK, '0, 10'd1), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_POP, '0, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_REMOVE, '0, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_REMOVE, '0, '0), 1,
                     make_result(cldl_pkg::ST_EMPTY, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_APPEND, 32'h12345678, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_POP, '0, '0), 1,
                     make_result(cldl_pkg::ST_DONE, 0, 0, '0)});
    rows.push_back('{make_item(cldl_pkg::OP_APPEND, 32'h1, '0), 0, none});
    rows.push_back('{make_item(cldl_pkg::OP_CLEAR, '0, '0), 1,
                     make_result(cldl_pkg::ST_DONE, 0, 0, '0)});
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_fixed, rows[i].fixed);
    // Fill to capacity and overflow.
    for (int i = 0; i < CAP; i++) begin
      send_item(make_item(cldl_pkg::OP_APPEND, $urandom(), '0), 0, none);
    end
    send_item(make_item(cldl_pkg::OP_APPEND, 32'hdeadbeef, '0), 1,
              make_result(cldl_pkg::ST_FULL, CAP, 1,
                          lst_count > 0 ? lst_data[lst_cur] : '0));
    hold_long = 1;
    for (int i = 0; i < 40; i++) send_item(random_item(), 0, none);
    hold_long = 0;
    send_item(make_item(cldl_pkg::OP_CLEAR, '0, '0), 0, none);
    for (int i = 0; i < 650; i++) send_item(random_item(), 0, none);
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    int hold;
    bit long_done;
    long_done = 0;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long && !long_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_done = 1;
      end
      hold = gap_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cldl_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.count !== want.count) begin
          $error("count exp %0d got %0d", want.count, out_data.count);
          errors++;
        end
        if (out_data.cursor_valid !== want.cursor_valid) begin
          $error("cursor_valid exp %0d got %0d", want.cursor_valid, out_data.cursor_valid);
          errors++;
        end
        if (out_data.cursor_value !== want.cursor_value) begin
          $error("cursor_value exp %h got %h", want.cursor_value, out_data.cursor_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    bit timed_out;
    timed_out = 0;
    @(negedge rst);
    fork
      begin
        wait (sending_done && pending_results.size() == 0);
        repeat (50) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCH_LIMIT);
        timed_out = 1;
      end
    join_any
    if (timed_out || pending_results.size() != 0) begin
      $display("** circular_list_with_cursor_core: FAILED **");
    end else if (errors == 0) begin
      $display("** circular_list_with_cursor_core: PASSED **");
    end else begin
      $display("** circular_list_with_cursor_core: FAILED **");
    end
    $finish;
  end
endmodule
